// ===== sv/dmsp_pkg.sv =====
// ----------------------------------------------------------------------------
// DHCP message stream parser package
// Shared section codes, option codes and the word format of the internal queue.
// ----------------------------------------------------------------------------
package dmsp_pkg;

  // Tag codes for each parsed byte; the parser state uses the same codes
  typedef enum logic [4:0] {
    SEC_OP         = 5'd0,
    SEC_HTYPE      = 5'd1,
    SEC_HLEN       = 5'd2,
    SEC_HOPS       = 5'd3,
    SEC_XID        = 5'd4,
    SEC_SECS       = 5'd5,
    SEC_FLAGS      = 5'd6,
    SEC_CIADDR     = 5'd7,
    SEC_YIADDR     = 5'd8,
    SEC_SIADDR     = 5'd9,
    SEC_GIADDR     = 5'd10,
    SEC_CHADDR     = 5'd11,
    SEC_SNAME      = 5'd12,
    SEC_FILE       = 5'd13,
    SEC_COOKIE     = 5'd14,
    SEC_CODE       = 5'd15,
    SEC_LENGTH     = 5'd16,
    SEC_VALUE      = 5'd17,
    SEC_PAD        = 5'd18,
    SEC_END        = 5'd19,
    SEC_IGNORED    = 5'd20,
    SEC_COOKIE_BAD = 5'd21
  } section_e;

  localparam logic [31:0] COOKIE_WORD  = 32'h6382_5363;
  localparam logic [7:0]  OPT_PAD      = 8'd0;
  localparam logic [7:0]  OPT_END      = 8'd255;
  localparam logic [7:0]  OPT_MSG_TYPE = 8'd53;
  localparam logic [7:0]  COOKIE_LAST  = 8'd3;
  localparam logic [7:0]  SHORT_FIELD_MAX = 8'd4;

  // One queued byte with its front-end classification
  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       is_pad;
    logic       is_end;
  } dmsp_word_t;

  // Byte length of each fixed header field
  function automatic logic [7:0] header_len(section_e s);
    logic [7:0] len;
    case (s)
      SEC_XID, SEC_CIADDR, SEC_YIADDR,
      SEC_SIADDR, SEC_GIADDR:           len = 8'd4;
      SEC_SECS, SEC_FLAGS:              len = 8'd2;
      SEC_CHADDR:                       len = 8'd16;
      SEC_SNAME:                        len = 8'd64;
      SEC_FILE:                         len = 8'd128;
      default:                          len = 8'd1;
    endcase
    return len;
  endfunction

endpackage

// ===== sv/dmsp_front.sv =====
// ----------------------------------------------------------------------------
// DHCP parser front end
// Accepts message bytes, classifies pad and end codes and queues the words.
// ----------------------------------------------------------------------------
module dmsp_front import dmsp_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       first_of_message_i,
  input  logic       last_of_message_i,
  output logic       head_valid_o,
  output dmsp_word_t head_word_o,
  input  logic       pop_i
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

  dmsp_word_t          mem_q [QueueDepth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                push;
  dmsp_word_t          in_word;

  // Classify the byte on the way in
  always_comb begin
    in_word.data   = data_byte_i;
    in_word.first  = first_of_message_i;
    in_word.last   = last_of_message_i;
    in_word.is_pad = (data_byte_i == OPT_PAD);
    in_word.is_end = (data_byte_i == OPT_END);
  end

  assign in_stall_o   = (count_q == FullCnt);
  assign push         = in_valid_i & ~in_stall_o;
  assign head_valid_o = (count_q != '0);
  assign head_word_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_word;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("queue count exceeds depth");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("pop from empty queue");

endmodule

// ===== sv/dmsp_back.sv =====
// ----------------------------------------------------------------------------
// DHCP parser back end
// Walks header, cookie and options one word per cycle, unless the output stalls, into an output register.
// ----------------------------------------------------------------------------
module dmsp_back import dmsp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        head_valid_i,
  input  dmsp_word_t  head_word_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  byte_value_o,
  output logic [4:0]  section_o,
  output logic [7:0]  index_in_field_o,
  output logic        field_done_o,
  output logic [31:0] field_value_o,
  output logic [7:0]  option_code_o,
  output logic [7:0]  option_length_o,
  output logic [7:0]  dhcp_type_o,
  output logic        dhcp_type_seen_o,
  output logic        cookie_error_o,
  output logic        options_ended_o,
  output logic        truncated_o
);

  // Parser state
  section_e    section_q, section_d;
  logic [7:0]  index_q, index_d;
  logic [31:0] acc_q, acc_d;
  logic [7:0]  code_q, code_d;
  logic [7:0]  length_q, length_d;
  logic [7:0]  type_q, type_d;
  logic        seen_q, seen_d;
  logic        cookie_err_q, cookie_err_d;
  logic        ended_q, ended_d;

  // State as seen by this word; a first-of-message word starts from reset
  section_e    cur_section;
  logic [7:0]  cur_index;
  logic [31:0] cur_acc;
  logic [7:0]  cur_code;
  logic [7:0]  cur_length;
  logic [7:0]  cur_type;
  logic        cur_seen;
  logic        cur_cookie_err;
  logic        cur_ended;

  // Per-word result
  section_e    tag;
  logic [7:0]  tag_index;
  logic        tag_done;
  logic [31:0] tag_value;
  logic [7:0]  tag_code;
  logic [7:0]  tag_length;

  logic [31:0] acc_shift;
  logic [7:0]  hdr_len;
  logic [8:0]  index_next;

  logic        out_valid_q;
  logic [7:0]  byte_value_q;
  section_e    tag_q;
  logic [7:0]  tag_index_q;
  logic        tag_done_q;
  logic [31:0] tag_value_q;
  logic [7:0]  tag_code_q;
  logic [7:0]  tag_length_q;
  logic [7:0]  out_type_q;
  logic        out_seen_q;
  logic        out_cookie_err_q;
  logic        out_ended_q;
  logic        truncated_q;

  assign pop_o = head_valid_i & (~out_valid_q | ~out_stall_i);

  always_comb begin
    if (head_word_i.first) begin
      cur_section    = SEC_OP;
      cur_index      = '0;
      cur_acc        = '0;
      cur_code       = '0;
      cur_length     = '0;
      cur_type       = '0;
      cur_seen       = 1'b0;
      cur_cookie_err = 1'b0;
      cur_ended      = 1'b0;
    end else begin
      cur_section    = section_q;
      cur_index      = index_q;
      cur_acc        = acc_q;
      cur_code       = code_q;
      cur_length     = length_q;
      cur_type       = type_q;
      cur_seen       = seen_q;
      cur_cookie_err = cookie_err_q;
      cur_ended      = ended_q;
    end
  end

  assign acc_shift  = {cur_acc[23:0], head_word_i.data};
  assign hdr_len    = header_len(cur_section);
  assign index_next = {1'b0, cur_index} + 9'd1;

  // Next state and per-word tag
  always_comb begin
    section_d    = cur_section;
    index_d      = cur_index;
    acc_d        = cur_acc;
    code_d       = cur_code;
    length_d     = cur_length;
    type_d       = cur_type;
    seen_d       = cur_seen;
    cookie_err_d = cur_cookie_err;
    ended_d      = cur_ended;
    tag          = SEC_IGNORED;
    tag_index    = '0;
    tag_done     = 1'b0;
    tag_value    = '0;
    tag_code     = '0;
    tag_length   = '0;

    if (cur_section inside {[SEC_OP:SEC_FILE]}) begin
      tag       = cur_section;
      tag_index = cur_index;
      acc_d     = acc_shift;
      if (index_next >= {1'b0, hdr_len}) begin
        tag_done = 1'b1;
        if (hdr_len <= SHORT_FIELD_MAX) begin
          tag_value = acc_shift;
        end
        section_d = section_e'(5'(cur_section + 5'd1));
        index_d   = '0;
        acc_d     = '0;
      end else begin
        index_d = index_next[7:0];
      end
    end else begin
      case (cur_section)
        SEC_COOKIE: begin
          tag       = SEC_COOKIE;
          tag_index = cur_index;
          acc_d     = acc_shift;
          if (cur_index >= COOKIE_LAST) begin
            tag_done  = 1'b1;
            tag_value = acc_shift;
            if (acc_shift != COOKIE_WORD) begin
              tag          = SEC_COOKIE_BAD;
              cookie_err_d = 1'b1;
              section_d    = SEC_IGNORED;
            end else begin
              section_d = SEC_CODE;
            end
            index_d = '0;
            acc_d   = '0;
          end else begin
            index_d = index_next[7:0];
          end
        end
        SEC_CODE: begin
          if (head_word_i.is_pad) begin
            tag      = SEC_PAD;
            tag_done = 1'b1;
          end else if (head_word_i.is_end) begin
            tag       = SEC_END;
            tag_done  = 1'b1;
            tag_code  = OPT_END;
            ended_d   = 1'b1;
            section_d = SEC_IGNORED;
          end else begin
            tag       = SEC_CODE;
            code_d    = head_word_i.data;
            length_d  = '0;
            tag_code  = head_word_i.data;
            section_d = SEC_LENGTH;
          end
        end
        SEC_LENGTH: begin
          tag        = SEC_LENGTH;
          length_d   = head_word_i.data;
          tag_code   = cur_code;
          tag_length = head_word_i.data;
          index_d    = '0;
          if (head_word_i.is_pad) begin
            // zero-length option ends on its length byte
            tag_done  = 1'b1;
            section_d = SEC_CODE;
          end else begin
            section_d = SEC_VALUE;
          end
        end
        SEC_VALUE: begin
          tag        = SEC_VALUE;
          tag_index  = cur_index;
          tag_code   = cur_code;
          tag_length = cur_length;
          if (cur_code == OPT_MSG_TYPE && cur_index == '0) begin
            type_d = head_word_i.data;
            seen_d = 1'b1;
          end
          if (index_next >= {1'b0, cur_length}) begin
            tag_done  = 1'b1;
            index_d   = '0;
            section_d = SEC_CODE;
          end else begin
            index_d = index_next[7:0];
          end
        end
        default: begin
          section_d = SEC_IGNORED;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      section_q    <= SEC_OP;
      index_q      <= '0;
      acc_q        <= '0;
      code_q       <= '0;
      length_q     <= '0;
      type_q       <= '0;
      seen_q       <= 1'b0;
      cookie_err_q <= 1'b0;
      ended_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (pop_o) begin
        section_q    <= section_d;
        index_q      <= index_d;
        acc_q        <= acc_d;
        code_q       <= code_d;
        length_q     <= length_d;
        type_q       <= type_d;
        seen_q       <= seen_d;
        cookie_err_q <= cookie_err_d;
        ended_q      <= ended_d;
        out_valid_q  <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register; holds while stalled
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      byte_value_q     <= head_word_i.data;
      tag_q            <= tag;
      tag_index_q      <= tag_index;
      tag_done_q       <= tag_done;
      tag_value_q      <= tag_value;
      tag_code_q       <= tag_code;
      tag_length_q     <= tag_length;
      out_type_q       <= type_d;
      out_seen_q       <= seen_d;
      out_cookie_err_q <= cookie_err_d;
      out_ended_q      <= ended_d;
      truncated_q      <= head_word_i.last & ~ended_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign byte_value_o        = byte_value_q;
  assign section_o           = tag_q;
  assign index_in_field_o    = tag_index_q;
  assign field_done_o        = tag_done_q;
  assign field_value_o       = tag_value_q;
  assign option_code_o       = tag_code_q;
  assign option_length_o     = tag_length_q;
  assign dhcp_type_o         = out_type_q;
  assign dhcp_type_seen_o    = out_seen_q;
  assign cookie_error_o      = out_cookie_err_q;
  assign options_ended_o     = out_ended_q;
  assign truncated_o         = truncated_q;

  a_err_end_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cookie_err_q && ended_q))
    else $error("cookie error and end option both set");

  a_type_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !seen_q |-> type_q == '0)
    else $error("message type latched without being seen");

  a_option_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (section_q == SEC_CODE || section_q == SEC_LENGTH || section_q == SEC_IGNORED)
      |-> (index_q == '0 && acc_q == '0))
    else $error("stale index or accumulator between options");

  a_pop_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> out_valid_q)
    else $error("popped word did not reach the result register");

endmodule

// ===== sv/dhcp_message_stream_parser.sv =====
// ----------------------------------------------------------------------------
// DHCP message stream parser
// Tags each DHCP/BOOTP message byte with its header field, cookie or option part.
// ----------------------------------------------------------------------------
// A byte accepted into the queue passes through the result register to the
// output, where it is held while the output stalls.
// Throughput: one byte per cycle while the output does not stall.
// The front queue holds QueueDepth words, so the input runs on for that many
// bytes while the output stalls.
// Reset clears the queue, the parser state (op field, flags clear) and the
// output valid; a first-of-message byte restarts parsing from the same state.
// ----------------------------------------------------------------------------
module dhcp_message_stream_parser import dmsp_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_of_message_i,
  input  logic        last_of_message_i,
  // tagged byte output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  byte_value_o,
  output logic [4:0]  section_o,
  output logic [7:0]  index_in_field_o,
  output logic        field_done_o,
  output logic [31:0] field_value_o,
  output logic [7:0]  option_code_o,
  output logic [7:0]  option_length_o,
  output logic [7:0]  dhcp_type_o,
  output logic        dhcp_type_seen_o,
  output logic        cookie_error_o,
  output logic        options_ended_o,
  output logic        truncated_o
);

  // Queue head between front and back
  logic       head_valid;
  dmsp_word_t head_word;
  logic       pop;

  // Front: accept, classify pad/end, queue the word
  dmsp_front #(
    .QueueDepth(QueueDepth)
  ) u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .data_byte_i        (data_byte_i),
    .first_of_message_i (first_of_message_i),
    .last_of_message_i  (last_of_message_i),
    .head_valid_o       (head_valid),
    .head_word_o        (head_word),
    .pop_i              (pop)
  );

  // Back: advance the parse by one word per cycle while not stalled and register the result;
  // drop a word from the queue only when the result register can take it
  dmsp_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .head_valid_i        (head_valid),
    .head_word_i         (head_word),
    .pop_o               (pop),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .byte_value_o        (byte_value_o),
    .section_o           (section_o),
    .index_in_field_o    (index_in_field_o),
    .field_done_o        (field_done_o),
    .field_value_o       (field_value_o),
    .option_code_o       (option_code_o),
    .option_length_o     (option_length_o),
    .dhcp_type_o         (dhcp_type_o),
    .dhcp_type_seen_o    (dhcp_type_seen_o),
    .cookie_error_o      (cookie_error_o),
    .options_ended_o     (options_ended_o),
    .truncated_o         (truncated_o)
  );

endmodule
